### sv/drik_pkg.sv
package drik_pkg;

    typedef logic signed [63:0] t_word;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT,
        OP_ATAN
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_ureq;

    typedef enum logic [1:0] {
        U_IDLE,
        U_NORM,
        U_RUN,
        U_FIN
    } t_ust;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LA,
        ST_LB,
        ST_XX,
        ST_YY,
        ST_ZZ,
        ST_DD,
        ST_SX,
        ST_P,
        ST_U1,
        ST_U2,
        ST_DP,
        ST_DIV,
        ST_V,
        ST_UU,
        ST_KV,
        ST_SQ,
        ST_CXY,
        ST_AT,
        ST_D1,
        ST_D2,
        ST_D3,
        ST_D4,
        ST_MT,
        ST_FAIL,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        REG_UPPER,
        REG_LOWER,
        REG_BASE,
        REG_PLAT
    } t_reg;

    localparam int MUL_STEPS  = 30;
    localparam int DIV_STEPS  = 51;
    localparam int SQRT_STEPS = 32;
    localparam int ATAN_STEPS = 24;

    localparam logic signed [31:0] HOME_ANGLE = 32'sd377487360;
    localparam t_word SQRT3_Q16  = 64'sd113512;
    localparam t_word K_LIMIT    = 64'sd268435456;
    localparam t_word NORM_LIMIT = 64'sd1099511627776;
    localparam t_word SQRT_BIT0  = 64'sh4000_0000_0000_0000;

    localparam logic [14:0] RST_UPPER = 15'd6400;
    localparam logic [14:0] RST_LOWER = 15'd12800;
    localparam logic [14:0] RST_BASE  = 15'd6400;
    localparam logic [14:0] RST_PLAT  = 15'd2560;

    // atan(2^-i) in degrees, 22 fraction bits
    function automatic logic [27:0] atan_q22(input logic [4:0] i);
        logic [27:0] v;
        case (i)
            5'd0:    v = 28'd188743680;
            5'd1:    v = 28'd111421900;
            5'd2:    v = 28'd58872272;
            5'd3:    v = 28'd29884485;
            5'd4:    v = 28'd15000234;
            5'd5:    v = 28'd7507429;
            5'd6:    v = 28'd3754631;
            5'd7:    v = 28'd1877430;
            5'd8:    v = 28'd938729;
            5'd9:    v = 28'd469366;
            5'd10:   v = 28'd234683;
            5'd11:   v = 28'd117342;
            5'd12:   v = 28'd58671;
            5'd13:   v = 28'd29335;
            5'd14:   v = 28'd14668;
            5'd15:   v = 28'd7334;
            5'd16:   v = 28'd3667;
            5'd17:   v = 28'd1833;
            5'd18:   v = 28'd917;
            5'd19:   v = 28'd458;
            5'd20:   v = 28'd229;
            5'd21:   v = 28'd115;
            5'd22:   v = 28'd57;
            5'd23:   v = 28'd29;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

endpackage

### sv/drik_unit.sv
module drik_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  drik_pkg::t_ureq i_req,
    input  drik_pkg::t_word i_a,
    input  drik_pkg::t_word i_b,
    output logic           o_done,
    output drik_pkg::t_word o_res
);
    import drik_pkg::*;

    t_ust r_st, n_st;
    t_op  r_op, n_op;
    t_word r_x, n_x, r_y, n_y, r_p, n_p, r_b, n_b, r_res, n_res;
    logic signed [31:0] r_acc, n_acc;
    logic [5:0] r_cnt, n_cnt, last;
    logic r_neg, n_neg, r_done, n_done;
    t_word t_div, d_div, sq_diff, x_sh, y_sh;
    logic signed [31:0] a_step;

    assign o_done = r_done;
    assign o_res  = r_res;

    always_comb begin
        unique case (r_op)
            OP_MUL:  last = 6'(MUL_STEPS - 1);
            OP_DIV:  last = 6'(DIV_STEPS - 1);
            OP_SQRT: last = 6'(SQRT_STEPS - 1);
            default: last = 6'(ATAN_STEPS - 1);
        endcase
    end

    assign t_div   = {r_p[62:0], r_x[DIV_STEPS-1]};
    assign d_div   = t_div - r_b;
    assign sq_diff = r_x - (r_y | r_b);
    assign x_sh    = r_x >>> r_cnt;
    assign y_sh    = r_y >>> r_cnt;
    assign a_step  = 32'(atan_q22(r_cnt[4:0]));

    always_comb begin
        n_st = r_st; n_op = r_op; n_x = r_x; n_y = r_y; n_p = r_p; n_b = r_b;
        n_acc = r_acc; n_cnt = r_cnt; n_neg = r_neg; n_res = r_res; n_done = 1'b0;
        unique case (r_st)
            U_IDLE: begin
                if (i_req.start) begin
                    n_op  = i_req.op;
                    n_cnt = '0;
                    n_p   = '0;
                    n_acc = '0;
                    n_neg = 1'b0;
                    n_st  = U_RUN;
                    case (i_req.op)
                        OP_MUL: begin
                            n_x   = i_a;
                            n_y   = i_b[63] ? -i_b : i_b;
                            n_neg = i_b[63];
                        end
                        OP_DIV: begin
                            n_x   = i_a[63] ? -i_a : i_a;
                            n_b   = i_b;
                            n_y   = '0;
                            n_neg = i_a[63];
                        end
                        OP_SQRT: begin
                            n_x = i_a;
                            n_y = '0;
                            n_b = SQRT_BIT0;
                        end
                        default: begin
                            n_x  = i_a;
                            n_y  = i_b;
                            n_st = U_NORM;
                        end
                    endcase
                end
            end
            U_NORM: begin
                // double the vector until one magnitude reaches the limit
                if (r_x < NORM_LIMIT && r_y < NORM_LIMIT && r_y > -NORM_LIMIT) begin
                    n_x = r_x <<< 1;
                    n_y = r_y <<< 1;
                end else begin
                    n_st = U_RUN;
                end
            end
            U_RUN: begin
                case (r_op)
                    OP_MUL: begin
                        if (r_y[0]) n_p = r_p + r_x;
                        n_x = r_x <<< 1;
                        n_y = r_y >>> 1;
                    end
                    OP_DIV: begin
                        n_p = d_div[63] ? t_div : d_div;
                        n_y = {r_y[62:0], ~d_div[63]};
                        n_x = r_x <<< 1;
                    end
                    OP_SQRT: begin
                        if (!sq_diff[63]) begin
                            n_x = sq_diff;
                            n_y = (r_y >>> 1) | r_b;
                        end else begin
                            n_y = r_y >>> 1;
                        end
                        n_b = r_b >>> 2;
                    end
                    default: begin
                        if (r_y > 0) begin
                            n_x   = r_x + y_sh;
                            n_y   = r_y - x_sh;
                            n_acc = r_acc + a_step;
                        end else if (r_y < 0) begin
                            n_x   = r_x - y_sh;
                            n_y   = r_y + x_sh;
                            n_acc = r_acc - a_step;
                        end
                    end
                endcase
                if (r_cnt == last) n_st = U_FIN;
                else n_cnt = r_cnt + 6'd1;
            end
            U_FIN: begin
                case (r_op)
                    OP_MUL:  n_res = r_neg ? -r_p : r_p;
                    OP_DIV:  n_res = r_neg ? -r_y : r_y;
                    OP_SQRT: n_res = r_y;
                    default: n_res = 64'(r_acc) <<< 1;
                endcase
                n_done = 1'b1;
                n_st   = U_IDLE;
            end
            default: n_st = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= U_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_x   <= n_x;
        r_y   <= n_y;
        r_p   <= n_p;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_res <= n_res;
    end

endmodule

### sv/delta_robot_inverse_kinematics.sv
// Flow: a home request goes straight from acceptance to the result state; a move
// request takes a data-dependent time (CORDIC pre-scaling); an out-of-reach move
// ends as soon as the failing check is reached.
// Throughput: one request at a time; the shared unit (one bit per cycle for
// multiply, divide and root, one CORDIC step per cycle) does the arithmetic.
// Reset (synchronous, active low): registers to defaults, joints to 90 deg,
// output empty.
module delta_robot_inverse_kinematics (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // target_x, target_y, target_z
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // delta_one, delta_two, delta_three,
                                       // move_time, unreachable, zero pad
    output logic        m_axis_tuser   // command
);
    import drik_pkg::*;

    // configuration
    logic [14:0] r_la, r_lb, r_br, r_pr;

    // control
    t_state r_state, n_state;
    logic   r_wait, n_wait;
    logic [1:0] r_arm, n_arm;
    logic   r_ovalid, n_ovalid;
    logic signed [31:0] r_joint [3];
    logic signed [31:0] n_joint [3];

    // working registers
    logic signed [15:0] r_x, n_x, r_y, n_y, r_z, n_z;
    t_word r_bq, n_bq, r_sx, n_sx, r_p, n_p, r_n, n_n, r_k, n_k;
    t_word r_u, n_u, r_v, n_v, r_d, n_d, r_t, n_t;
    logic signed [31:0] r_ang [3];
    logic signed [31:0] n_ang [3];
    logic signed [32:0] r_dl, n_dl;
    logic signed [39:0] r_m, n_m, r_w, n_w, cd_full;
    logic [32:0] r_ad, n_ad, r_maxd, n_maxd;
    logic [39:0] mt_full;
    logic signed [16:0] r_cd [3];
    logic signed [16:0] n_cd [3];
    logic [15:0] r_mt, n_mt;
    logic r_unr, n_unr, r_cmd, n_cmd;
    logic [71:0] r_odata, n_odata;
    logic r_ouser, n_ouser;

    // shared unit
    t_ureq ureq;
    t_word ua, ub, u_res;
    logic  u_done;

    t_word la_w, lb_w, d_w, x_w, y_w, z_w;
    logic signed [15:0] d16;

    assign d16  = $signed({1'b0, r_br}) - $signed({1'b0, r_pr});
    assign la_w = {49'd0, r_la};
    assign lb_w = {49'd0, r_lb};
    assign d_w  = 64'(d16);
    assign x_w  = 64'(r_x);
    assign y_w  = 64'(r_y);
    assign z_w  = 64'(r_z);

    assign cd_full = (r_w + (r_w < 0 ? 40'sd4194303 : 40'sd0)) >>> 22;
    assign mt_full = {7'd0, r_maxd} * 40'd100;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    drik_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ureq),
        .i_a     (ua),
        .i_b     (ub),
        .o_done  (u_done),
        .o_res   (u_res)
    );

    // operand selection for the shared unit
    always_comb begin
        ureq.op = OP_MUL;
        ua      = '0;
        ub      = '0;
        case (r_state)
            ST_LA:   begin ua = la_w; ub = la_w; end
            ST_LB:   begin ua = lb_w; ub = lb_w; end
            ST_XX:   begin ua = x_w;  ub = x_w;  end
            ST_YY:   begin ua = y_w;  ub = y_w;  end
            ST_ZZ:   begin ua = z_w;  ub = z_w;  end
            ST_DD:   begin ua = d_w;  ub = d_w;  end
            ST_SX:   begin ua = x_w;  ub = SQRT3_Q16; end
            ST_DP:   begin ua = r_p;  ub = d_w;  end
            ST_DIV:  begin ureq.op = OP_DIV; ua = r_n; ub = lb_w <<< 8; end
            ST_UU:   begin ua = r_u;  ub = r_u;  end
            ST_KV:   begin ua = r_k;  ub = r_v;  end
            ST_SQ:   begin ureq.op = OP_SQRT; ua = r_d; end
            ST_AT:   begin ureq.op = OP_ATAN; ua = r_n; ub = r_t; end
            default: ;
        endcase
        // issue once per step; a negative discriminant never reaches the root
        case (r_state)
            ST_LA, ST_LB, ST_XX, ST_YY, ST_ZZ, ST_DD, ST_SX, ST_DP, ST_DIV,
            ST_UU, ST_KV, ST_AT:
                ureq.start = ~r_wait;
            ST_SQ:
                ureq.start = ~r_wait & ~r_d[63];
            default:
                ureq.start = 1'b0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_arm = r_arm; n_ovalid = r_ovalid;
        n_x = r_x; n_y = r_y; n_z = r_z;
        n_bq = r_bq; n_sx = r_sx; n_p = r_p; n_n = r_n; n_k = r_k;
        n_u = r_u; n_v = r_v; n_d = r_d; n_t = r_t;
        n_dl = r_dl; n_m = r_m; n_w = r_w; n_ad = r_ad; n_maxd = r_maxd;
        n_mt = r_mt; n_unr = r_unr; n_cmd = r_cmd;
        n_odata = r_odata; n_ouser = r_ouser;
        n_joint = r_joint; n_ang = r_ang; n_cd = r_cd;

        n_wait = r_wait;
        if (ureq.start) n_wait = 1'b1;
        if (u_done)     n_wait = 1'b0;

        // drop the held result once taken
        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_x    = s_axis_tdata[15:0];
                    n_y    = s_axis_tdata[31:16];
                    n_z    = s_axis_tdata[47:32];
                    n_maxd = '0;
                    n_arm  = '0;
                    n_cd   = '{default: '0};
                    n_mt   = '0;
                    n_unr  = 1'b0;
                    n_cmd  = s_axis_tuser;
                    if (s_axis_tuser) begin
                        n_joint = '{default: HOME_ANGLE};
                        n_state = ST_DONE;
                    end else if (r_lb == '0) begin
                        n_state = ST_FAIL;
                    end else begin
                        n_state = ST_LA;
                    end
                end
            end
            ST_LA: if (u_done) begin n_bq = u_res;        n_state = ST_LB; end
            ST_LB: if (u_done) begin n_bq = r_bq - u_res; n_state = ST_XX; end
            ST_XX: if (u_done) begin n_bq = r_bq - u_res; n_state = ST_YY; end
            ST_YY: if (u_done) begin n_bq = r_bq - u_res; n_state = ST_ZZ; end
            ST_ZZ: if (u_done) begin n_bq = r_bq - u_res; n_state = ST_DD; end
            ST_DD: if (u_done) begin n_bq = r_bq - u_res; n_state = ST_SX; end
            ST_SX: if (u_done) begin n_sx = u_res;        n_state = ST_P;  end
            ST_P: begin
                case (r_arm)
                    2'd0:    n_p = r_sx + (y_w <<< 16);
                    2'd1:    n_p = (y_w <<< 16) - r_sx;
                    default: n_p = -(y_w <<< 17);
                endcase
                n_state = ST_U1;
            end
            ST_U1: begin
                n_t     = (r_p <<< 1) - (d_w <<< 18);
                n_state = ST_U2;
            end
            ST_U2: begin
                // divide by 256, truncating toward zero
                n_u     = (r_t + (r_t < 0 ? 64'sd255 : 64'sd0)) >>> 8;
                n_state = ST_DP;
            end
            ST_DP:  if (u_done) begin n_n = (r_bq <<< 16) + u_res; n_state = ST_DIV; end
            ST_DIV: if (u_done) begin n_k = u_res + (z_w <<< 9);   n_state = ST_V;   end
            ST_V: begin
                n_v = r_k - (z_w <<< 10);
                if (r_k == '0 || r_k >= K_LIMIT || r_k <= -K_LIMIT) n_state = ST_FAIL;
                else n_state = ST_UU;
            end
            ST_UU: if (u_done) begin n_d = u_res;               n_state = ST_KV; end
            ST_KV: if (u_done) begin n_d = r_d - (u_res <<< 2); n_state = ST_SQ; end
            ST_SQ: begin
                if (!r_wait && r_d[63]) n_state = ST_FAIL;
                else if (u_done) begin
                    n_d     = u_res;
                    n_state = ST_CXY;
                end
            end
            ST_CXY: begin
                n_n     = r_k[63] ? -(r_k <<< 1) : (r_k <<< 1);
                n_t     = r_k[63] ? r_d + r_u : r_d - r_u;
                n_state = ST_AT;
            end
            ST_AT: begin
                if (u_done) begin
                    n_ang[r_arm] = u_res[31:0];
                    if (r_arm == 2'd2) begin
                        n_arm   = '0;
                        n_state = ST_D1;
                    end else begin
                        n_arm   = r_arm + 2'd1;
                        n_state = ST_P;
                    end
                end
            end
            ST_D1: begin
                n_dl    = 33'(r_ang[r_arm]) - 33'(r_joint[r_arm]);
                n_state = ST_D2;
            end
            ST_D2: begin
                n_m     = 40'(r_dl) * 40'sd100;
                n_ad    = r_dl[32] ? 33'(-r_dl) : 33'(r_dl);
                n_state = ST_D3;
            end
            ST_D3: begin
                if (r_ad > r_maxd) n_maxd = r_ad;
                n_w     = r_m + 40'sd2097152;
                n_state = ST_D4;
            end
            ST_D4: begin
                n_cd[r_arm] = cd_full[16:0];
                if (r_arm == 2'd2) begin
                    n_arm   = '0;
                    n_state = ST_MT;
                end else begin
                    n_arm   = r_arm + 2'd1;
                    n_state = ST_D1;
                end
            end
            ST_MT: begin
                n_mt    = mt_full[37:22];
                n_joint = r_ang;
                n_state = ST_DONE;
            end
            ST_FAIL: begin
                n_cd    = '{default: '0};
                n_mt    = '0;
                n_unr   = 1'b1;
                n_cmd   = 1'b0;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {4'd0, r_unr, r_mt, r_cd[2], r_cd[1], r_cd[0]};
                    n_ouser  = r_cmd;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wait   <= 1'b0;
            r_arm    <= '0;
            r_ovalid <= 1'b0;
            r_joint  <= '{default: HOME_ANGLE};
            r_la     <= RST_UPPER;
            r_lb     <= RST_LOWER;
            r_br     <= RST_BASE;
            r_pr     <= RST_PLAT;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_arm    <= n_arm;
            r_ovalid <= n_ovalid;
            r_joint  <= n_joint;
            if (i_cfg_we) begin
                unique case (t_reg'(i_cfg_index))
                    REG_UPPER: r_la <= i_cfg_data;
                    REG_LOWER: r_lb <= i_cfg_data;
                    REG_BASE:  r_br <= i_cfg_data;
                    REG_PLAT:  r_pr <= i_cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_bq    <= n_bq;
        r_sx    <= n_sx;
        r_p     <= n_p;
        r_n     <= n_n;
        r_k     <= n_k;
        r_u     <= n_u;
        r_v     <= n_v;
        r_d     <= n_d;
        r_t     <= n_t;
        r_ang   <= n_ang;
        r_dl    <= n_dl;
        r_m     <= n_m;
        r_w     <= n_w;
        r_ad    <= n_ad;
        r_maxd  <= n_maxd;
        r_cd    <= n_cd;
        r_mt    <= n_mt;
        r_unr   <= n_unr;
        r_cmd   <= n_cmd;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
    end

endmodule

### sv/drik_checker.sv
module drik_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after a request");

    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[67] |-> m_axis_tdata[66:0] == '0 && !m_axis_tuser)
        else $error("unreachable result carries motion");

    a_home_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("home result carries data");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind delta_robot_inverse_kinematics drik_checker u_drik_checker (.*);
